/* rtl/core/csp_pkg.sv */
// ============================================================================
// Cubic spline evaluator package
// Shared constants, control types and rounding helpers for the spline core.
// ============================================================================
package csp_pkg;

   // Default sizes of the knot table and the fixed-point format
   localparam int MAX_KNOTS_DEF = 64;
   localparam int FRAC_BITS_DEF = 16;

   // Widths fixed by the word format
   localparam int DATA_W = 32;
   localparam int IDX_W  = 6;
   localparam int CFG_W  = 7;

   // Request type codes
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // Status codes
   localparam logic STAT_OK  = 1'b0;
   localparam logic STAT_ERR = 1'b1;

   // Control word from the sequencer to the shared arithmetic unit
   typedef struct packed {
      logic start;
      logic is_div;
   } alu_ctl_type;

   // Round a signed 64-bit value to nearest over 30 bits, ties away from zero.
   function automatic logic [63:0] rnd30(input logic [63:0] v);
      logic [63:0] m;
      logic [64:0] s;
      logic [63:0] r;
      m = v[63] ? (~v + 64'd1) : v;
      s = {1'b0, m} + 65'h0_2000_0000;
      r = 64'(s[64:30]);
      return v[63] ? (~r + 64'd1) : r;
   endfunction

endpackage

/* rtl/core/csp_ram.sv */
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ============================================================================
module csp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/csp_alu.sv */
// ============================================================================
// Spline shared arithmetic unit
// A 64x64 multiplier built from four passes of one 32x32 multiplier, and a
// restoring divider that retires one quotient bit per cycle.
// ============================================================================
module csp_alu (
   input  logic                 clock,
   input  logic                 reset,
   input  csp_pkg::alu_ctl_type ctl,
   input  logic [63:0]          mul_a,
   input  logic [63:0]          mul_b,
   input  logic [64:0]          div_dividend,
   input  logic [32:0]          div_divisor,
   output logic                 done,
   output logic [127:0]         prod,
   output logic [63:0]          quot
);

   localparam logic [6:0] MUL_LAST = 7'd4;
   localparam logic [6:0] DIV_LAST = 7'd64;

   logic         busy_ff, busy_in;
   logic         is_div_ff, is_div_in;
   logic         done_ff, done_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [63:0]  a_ff, a_in, b_ff, b_in;
   logic [63:0]  pp_ff, pp_in;
   logic [127:0] acc_ff, acc_in;
   logic [32:0]  rem_ff, rem_in;
   logic [64:0]  dvd_ff, dvd_in;
   logic [32:0]  dvs_ff, dvs_in;

   logic [31:0]  a_part, b_part;
   logic [127:0] pp_shifted;
   logic [33:0]  trial;
   logic         fits;
   logic         last;

   // Operand halves for the current partial product
   assign a_part = cnt_ff[1] ? a_ff[63:32] : a_ff[31:0];
   assign b_part = cnt_ff[0] ? b_ff[63:32] : b_ff[31:0];

   // Place the previous partial product at its weight
   always_comb begin
      unique case (cnt_ff)
         7'd2, 7'd3: pp_shifted = {32'd0, pp_ff, 32'd0};
         7'd4:       pp_shifted = {pp_ff, 64'd0};
         default:    pp_shifted = {64'd0, pp_ff};
      endcase
   end

   // Restoring divide step
   assign trial = {rem_ff, dvd_ff[64]};
   assign fits  = trial >= {1'b0, dvs_ff};
   assign last  = is_div_ff ? (cnt_ff == DIV_LAST) : (cnt_ff == MUL_LAST);

   // Next-state logic
   always_comb begin
      busy_in   = busy_ff;
      is_div_in = is_div_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      pp_in     = pp_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      dvd_in    = dvd_ff;
      dvs_in    = dvs_ff;
      if (ctl.start) begin
         busy_in   = 1'b1;
         is_div_in = ctl.is_div;
         cnt_in    = '0;
         a_in      = mul_a;
         b_in      = mul_b;
         acc_in    = '0;
         rem_in    = '0;
         dvd_in    = div_dividend;
         dvs_in    = div_divisor;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 7'd1;
         if (is_div_ff) begin
            rem_in = fits ? 33'(trial - {1'b0, dvs_ff}) : trial[32:0];
            dvd_in = {dvd_ff[63:0], fits};
         end else begin
            pp_in = 64'(a_part) * 64'(b_part);
            if (cnt_ff != 7'd0) begin
               acc_in = acc_ff + pp_shifted;
            end
         end
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      is_div_ff <= is_div_in;
      cnt_ff    <= cnt_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      pp_ff     <= pp_in;
      acc_ff    <= acc_in;
      rem_ff    <= rem_in;
      dvd_ff    <= dvd_in;
      dvs_ff    <= dvs_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;
   assign quot = dvd_ff[63:0];

endmodule

/* rtl/core/cubic_spline_evaluator.sv */
// ============================================================================
// Cubic spline evaluator
// Knot table with binary search and cubic spline evaluation.
// ============================================================================
// Usage:
//   Request words arrive on req_valid / req_stall. A load word (req_type low)
//   writes one knot into the table; a query word evaluates the spline at
//   req_query_coord. Every request gives exactly one response word on
//   rsp_valid / rsp_stall; loads answer with a zero value and good status.
//   csr_knots_in_use sets how many knots take part; write it only when idle.
//   A query walks a binary search of up to log2(knots)+1 probes, then runs
//   eleven 64-bit multiplies, each built from four partial products, and
//   one divide by the knot spacing on the one shared arithmetic unit. An
//   empty table or an edge query skips the arithmetic. The multiplies and
//   the divider take most of the time of an interpolating query.
//   req_stall stays high from acceptance until the result is handed to the
//   output register; a waiting response does not block the next request.
//   If rsp_stall holds, the block finishes its work and waits for the
//   output register to empty. Reset clears the control state and the knot
//   count; the table contents are left as they are and must be loaded.
// ============================================================================
module cubic_spline_evaluator #(
   parameter int MAX_KNOTS = csp_pkg::MAX_KNOTS_DEF,
   parameter int FRAC_BITS = csp_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_type,
   input  logic [csp_pkg::IDX_W-1:0]   req_knot_index,
   input  logic signed [csp_pkg::DATA_W-1:0] req_knot_coord,
   input  logic signed [csp_pkg::DATA_W-1:0] req_knot_value,
   input  logic signed [csp_pkg::DATA_W-1:0] req_knot_second_deriv,
   input  logic signed [csp_pkg::DATA_W-1:0] req_query_coord,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [csp_pkg::DATA_W-1:0] rsp_interp_value,
   output logic                        rsp_status,
   // configuration channel
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [csp_pkg::CFG_W-1:0]   csr_knots_in_use
);

   localparam int AW = $clog2(MAX_KNOTS);
   localparam int CW = $clog2(MAX_KNOTS + 1);
   localparam logic [32:0] DEN      = 33'(64'd6 << FRAC_BITS);
   localparam logic [64:0] HALF_DEN = 65'(DEN >> 1);
   localparam logic [64:0] RND_F    = 65'(1) << (FRAC_BITS - 1);
   localparam logic [63:0] ONE_Q30  = 64'h4000_0000;
   localparam logic [63:0] RECIP3   = 64'h5555_5555_5555_5556;
   localparam logic signed [63:0] POS_MAX = 64'sd2147483647;
   localparam logic signed [63:0] NEG_MIN = -64'sd2147483648;

   typedef enum logic [3:0] {
      S_IDLE, S_PROBE, S_CMP, S_PICK, S_EDGE, S_RHI, S_RLO, S_CHECK,
      S_GO, S_WAIT, S_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_SQ, OP_T, OP_H, OP_WW, OP_WWW, OP_TT, OP_TTT, OP_WU, OP_TU,
      OP_WS, OP_TS, OP_EH
   } op_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   logic [csp_pkg::CFG_W-1:0] knots_ff, knots_in;
   logic [31:0] y_ff, y_in;
   logic [CW-1:0] n_ff, n_in, lo_ff, lo_in, len_ff, len_in;
   logic [31:0] x0_ff, x0_in, x1_ff, x1_in;
   logic [31:0] u0_ff, u0_in, u1_ff, u1_in;
   logic [31:0] s0_ff, s0_in, s1_ff, s1_in;
   logic [63:0] sq_ff, sq_in, t_ff, t_in, w_ff, w_in, h_ff, h_in;
   logic [63:0] v2_ff, v2_in, cw_ff, cw_in, ct_ff, ct_in;
   logic [63:0] acc_ff, acc_in, lin_ff, lin_in, e_ff, e_in;
   logic [31:0] res_val_ff, res_val_in;
   logic        res_st_ff, res_st_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_val_ff, rsp_val_in;
   logic        rsp_st_ff, rsp_st_in;

   logic           req_accept;
   logic           load_wr;
   logic [CW-1:0]  n_eff;
   logic [CW-1:0]  half, mid;
   logic [AW-1:0]  rd_addr;
   logic [31:0]    coord_rd, value_rd, deriv_rd;
   logic [32:0]    dk, dy1;
   logic           dk_bad;
   logic [63:0]    e_mag;

   csp_pkg::alu_ctl_type alu_ctl;
   logic [63:0]  mul_a, mul_b;
   logic [64:0]  div_dividend;
   logic [32:0]  div_divisor;
   logic         alu_done;
   logic [127:0] alu_prod;
   logic [63:0]  alu_quot;
   logic [63:0]  prod_lo;

   logic         eh_ovf;
   logic [63:0]  eh_r, eh_cub, eh_sum;
   logic [31:0]  eh_val;

   // Handshakes
   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign csr_ready  = 1'b1;
   assign load_wr    = req_accept && (req_type == csp_pkg::REQ_LOAD) &&
                       (32'(req_knot_index) < 32'(MAX_KNOTS));

   // Knot tables
   csp_ram #(.WIDTH(csp_pkg::DATA_W), .DEPTH(MAX_KNOTS)) u_coord_ram (
      .clock(clock), .wr_en(load_wr), .wr_addr(AW'(req_knot_index)),
      .wr_data(req_knot_coord), .rd_addr(rd_addr), .rd_data(coord_rd));

   csp_ram #(.WIDTH(csp_pkg::DATA_W), .DEPTH(MAX_KNOTS)) u_value_ram (
      .clock(clock), .wr_en(load_wr), .wr_addr(AW'(req_knot_index)),
      .wr_data(req_knot_value), .rd_addr(rd_addr), .rd_data(value_rd));

   csp_ram #(.WIDTH(csp_pkg::DATA_W), .DEPTH(MAX_KNOTS)) u_deriv_ram (
      .clock(clock), .wr_en(load_wr), .wr_addr(AW'(req_knot_index)),
      .wr_data(req_knot_second_deriv), .rd_addr(rd_addr), .rd_data(deriv_rd));

   // Shared arithmetic unit
   csp_alu u_alu (
      .clock(clock), .reset(reset), .ctl(alu_ctl),
      .mul_a(mul_a), .mul_b(mul_b),
      .div_dividend(div_dividend), .div_divisor(div_divisor),
      .done(alu_done), .prod(alu_prod), .quot(alu_quot));

   // Knot count clamped to the table size
   assign n_eff = (32'(knots_ff) < 32'(MAX_KNOTS)) ? CW'(knots_ff) : CW'(MAX_KNOTS);

   // Binary search probe
   assign half = len_ff >> 1;
   assign mid  = lo_ff + half;

   // Spacing of the bracketing pair and offset of the query
   assign dk     = {x1_ff[31], x1_ff} - {x0_ff[31], x0_ff};
   assign dy1    = {y_ff[31], y_ff} - {x0_ff[31], x0_ff};
   assign dk_bad = dk[32] || (dk == 33'd0);
   assign e_mag  = e_ff[63] ? (~e_ff + 64'd1) : e_ff;

   // Operand selection for the current step. The scale factor h divides by
   // six times one in the fixed-point format: the shift takes out the power
   // of two and a reciprocal multiplication by one third does the rest.
   always_comb begin
      mul_a = w_ff;
      mul_b = w_ff;
      unique case (op_ff)
         OP_SQ:  begin mul_a = {32'd0, dk[31:0]}; mul_b = {32'd0, dk[31:0]}; end
         OP_H:   begin
            mul_a = 64'(({1'b0, sq_ff} + HALF_DEN) >> (FRAC_BITS + 1));
            mul_b = RECIP3;
         end
         OP_WWW: begin mul_a = v2_ff; mul_b = w_ff; end
         OP_TT:  begin mul_a = t_ff; mul_b = t_ff; end
         OP_TTT: begin mul_a = v2_ff; mul_b = t_ff; end
         OP_WU:  begin mul_a = w_ff; mul_b = 64'(signed'(u0_ff)); end
         OP_TU:  begin mul_a = t_ff; mul_b = 64'(signed'(u1_ff)); end
         OP_WS:  begin mul_a = cw_ff; mul_b = 64'(signed'(s0_ff)); end
         OP_TS:  begin mul_a = ct_ff; mul_b = 64'(signed'(s1_ff)); end
         OP_EH:  begin mul_a = e_mag; mul_b = h_ff; end
         default: begin mul_a = w_ff; mul_b = w_ff; end
      endcase
   end

   // Rounded quotient of the query offset over the knot spacing
   assign div_dividend = 65'({dy1[31:0], 30'd0}) + 65'(dk[31:1]);
   assign div_divisor  = {1'b0, dk[31:0]};

   assign prod_lo = alu_prod[63:0];

   // Final step: scale, round and saturate
   assign eh_ovf = |alu_prod[127:63];
   assign eh_r   = 64'(({1'b0, alu_prod[63:0]} + RND_F) >> FRAC_BITS);
   assign eh_cub = e_ff[63] ? (~eh_r + 64'd1) : eh_r;
   assign eh_sum = lin_ff + eh_cub;

   always_comb begin
      priority if (eh_ovf) begin
         eh_val = e_ff[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      end else if ($signed(eh_sum) > POS_MAX) begin
         eh_val = 32'h7FFF_FFFF;
      end else if ($signed(eh_sum) < NEG_MIN) begin
         eh_val = 32'h8000_0000;
      end else begin
         eh_val = eh_sum[31:0];
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      knots_in     = knots_ff;
      y_in         = y_ff;
      n_in         = n_ff;
      lo_in        = lo_ff;
      len_in       = len_ff;
      x0_in        = x0_ff;
      x1_in        = x1_ff;
      u0_in        = u0_ff;
      u1_in        = u1_ff;
      s0_in        = s0_ff;
      s1_in        = s1_ff;
      sq_in        = sq_ff;
      t_in         = t_ff;
      w_in         = w_ff;
      h_in         = h_ff;
      v2_in        = v2_ff;
      cw_in        = cw_ff;
      ct_in        = ct_ff;
      acc_in       = acc_ff;
      lin_in       = lin_ff;
      e_in         = e_ff;
      res_val_in   = res_val_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_st_in    = rsp_st_ff;
      alu_ctl      = '0;
      rd_addr      = '0;

      // Configuration write
      if (csr_valid && csr_ready) begin
         knots_in = csr_knots_in_use;
      end

      // Output register drains when taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               res_val_in = '0;
               res_st_in  = csp_pkg::STAT_OK;
               if (req_type == csp_pkg::REQ_QUERY) begin
                  y_in   = req_query_coord;
                  n_in   = n_eff;
                  lo_in  = '0;
                  len_in = n_eff;
                  if (n_eff == '0) begin
                     res_st_in = csp_pkg::STAT_ERR;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_PROBE;
                  end
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_PROBE: begin
            rd_addr  = AW'(mid);
            state_in = S_CMP;
         end
         S_CMP: begin
            if ($signed(coord_rd) < $signed(y_ff)) begin
               lo_in  = mid + CW'(1);
               len_in = len_ff - half - CW'(1);
            end else begin
               len_in = half;
            end
            state_in = (len_in == '0) ? S_PICK : S_PROBE;
         end
         S_PICK: begin
            priority if (lo_ff >= n_ff) begin
               rd_addr  = AW'(n_ff - CW'(1));
               state_in = S_EDGE;
            end else if (lo_ff == '0) begin
               rd_addr  = '0;
               state_in = S_EDGE;
            end else begin
               rd_addr  = AW'(lo_ff);
               state_in = S_RHI;
            end
         end
         S_EDGE: begin
            res_val_in = value_rd;
            state_in   = S_DONE;
         end
         S_RHI: begin
            x1_in    = coord_rd;
            u1_in    = value_rd;
            s1_in    = deriv_rd;
            rd_addr  = AW'(lo_ff - CW'(1));
            state_in = S_RLO;
         end
         S_RLO: begin
            x0_in    = coord_rd;
            u0_in    = value_rd;
            s0_in    = deriv_rd;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (dk_bad) begin
               res_st_in = csp_pkg::STAT_ERR;
               state_in  = S_DONE;
            end else begin
               op_in    = OP_SQ;
               state_in = S_GO;
            end
         end
         S_GO: begin
            alu_ctl.start  = 1'b1;
            alu_ctl.is_div = (op_ff == OP_T);
            state_in       = S_WAIT;
         end
         S_WAIT: begin
            if (alu_done) begin
               state_in = S_GO;
               unique case (op_ff)
                  OP_SQ: begin
                     sq_in = prod_lo;
                     op_in = OP_T;
                  end
                  OP_T: begin
                     t_in  = alu_quot;
                     w_in  = ONE_Q30 - alu_quot;
                     op_in = OP_H;
                  end
                  OP_H: begin
                     h_in  = alu_prod[127:64];
                     op_in = OP_WW;
                  end
                  OP_WW: begin
                     v2_in = csp_pkg::rnd30(prod_lo);
                     op_in = OP_WWW;
                  end
                  OP_WWW: begin
                     cw_in = csp_pkg::rnd30(prod_lo) - w_ff;
                     op_in = OP_TT;
                  end
                  OP_TT: begin
                     v2_in = csp_pkg::rnd30(prod_lo);
                     op_in = OP_TTT;
                  end
                  OP_TTT: begin
                     ct_in = csp_pkg::rnd30(prod_lo) - t_ff;
                     op_in = OP_WU;
                  end
                  OP_WU: begin
                     acc_in = prod_lo;
                     op_in  = OP_TU;
                  end
                  OP_TU: begin
                     lin_in = csp_pkg::rnd30(acc_ff + prod_lo);
                     op_in  = OP_WS;
                  end
                  OP_WS: begin
                     acc_in = prod_lo;
                     op_in  = OP_TS;
                  end
                  OP_TS: begin
                     e_in  = csp_pkg::rnd30(acc_ff + prod_lo);
                     op_in = OP_EH;
                  end
                  OP_EH: begin
                     res_val_in = eh_val;
                     state_in   = S_DONE;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_val_in   = res_val_ff;
               rsp_st_in    = res_st_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_SQ;
         knots_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         knots_ff     <= knots_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      y_ff       <= y_in;
      n_ff       <= n_in;
      lo_ff      <= lo_in;
      len_ff     <= len_in;
      x0_ff      <= x0_in;
      x1_ff      <= x1_in;
      u0_ff      <= u0_in;
      u1_ff      <= u1_in;
      s0_ff      <= s0_in;
      s1_ff      <= s1_in;
      sq_ff      <= sq_in;
      t_ff       <= t_in;
      w_ff       <= w_in;
      h_ff       <= h_in;
      v2_ff      <= v2_in;
      cw_ff      <= cw_in;
      ct_ff      <= ct_in;
      acc_ff     <= acc_in;
      lin_ff     <= lin_in;
      e_ff       <= e_in;
      res_val_ff <= res_val_in;
      res_st_ff  <= res_st_in;
      rsp_val_ff <= rsp_val_in;
      rsp_st_ff  <= rsp_st_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_interp_value = rsp_val_ff;
   assign rsp_status       = rsp_st_ff;

endmodule
